### rtl/command_line_reply_parser_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef COMMAND_LINE_REPLY_PARSER_UNIT_DEFINES_SVH
`define COMMAND_LINE_REPLY_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/crp_pkg.sv
package crp_pkg;

    localparam int MAX_LINE = 512;
    localparam int LC_W     = $clog2(MAX_LINE);

    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam logic OP_OPEN = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] NOOP_WORD = "NOOP";
    localparam logic [31:0] EHLO_WORD = "EHLO";

    localparam logic [2:0] RC_BANNER  = 3'd0;
    localparam logic [2:0] RC_NOCAP   = 3'd1;
    localparam logic [2:0] RC_TLSCAP  = 3'd2;
    localparam logic [2:0] RC_OK      = 3'd3;
    localparam logic [2:0] RC_SYNTAX  = 3'd4;
    localparam logic [2:0] RC_UNKNOWN = 3'd5;
    localparam logic [2:0] RC_VERSION = 3'd6;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_CMD,
        PH_CLOSED
    } t_crp_phase;

    typedef enum logic [2:0] {
        PC_EMPTY,
        PC_ONE,
        PC_ONE_DOT,
        PC_ONE_DOT_ZERO,
        PC_DIGITS,
        PC_DIGITS_DOT,
        PC_VERSION,
        PC_BAD
    } t_crp_pclass;

    typedef enum logic [2:0] {
        EV_BANNER,
        EV_OK,
        EV_CAP,
        EV_SYNTAX,
        EV_UNKNOWN,
        EV_VERSION
    } t_crp_event;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_crp_in;

    typedef struct packed {
        logic [2:0] reply_code;
        logic       close_after;
    } t_crp_out;

    typedef struct packed {
        logic [1:0]  verb_match;
        logic        in_parameter;
        t_crp_pclass param_class;
    } t_crp_line;

    typedef struct packed {
        logic full;
        logic empty;
    } t_crp_q_status;

    localparam t_crp_line LINE_CLEAR = '{verb_match: 2'b11, in_parameter: 1'b0,
                                         param_class: PC_EMPTY};

    function automatic logic ev_closes(input t_crp_event ev);
        logic res;
        case (ev)
            EV_SYNTAX, EV_UNKNOWN, EV_VERSION: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

### rtl/crp_front.sv
module crp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  crp_pkg::t_crp_in      i_in_data,
    input  logic                  i_can_push,
    output logic                  o_in_ready,
    output logic                  o_push,
    output crp_pkg::t_crp_event   o_push_event
);

    crp_pkg::t_crp_phase  r_phase, n_phase;
    crp_pkg::t_crp_line   r_line, n_line;
    logic [crp_pkg::LC_W-1:0] r_count, n_count;
    logic                 r_pend_cr, n_pend_cr;

    logic                 acc;
    logic                 has_res;
    crp_pkg::t_crp_event  res_ev;
    crp_pkg::t_crp_line   fed;
    crp_pkg::t_crp_line   fin;
    logic [crp_pkg::LC_W:0]   count_inc;
    logic [crp_pkg::LC_W-1:0] matched;

    function automatic crp_pkg::t_crp_pclass next_pclass(
        input logic [7:0] c,
        input crp_pkg::t_crp_pclass pc
    );
        crp_pkg::t_crp_pclass res;
        logic digit;
        digit = (c >= crp_pkg::CH_ZERO) && (c <= crp_pkg::CH_NINE);
        res = crp_pkg::PC_BAD;
        if (digit) begin
            case (pc)
                crp_pkg::PC_EMPTY:
                    res = (c == crp_pkg::CH_ONE) ? crp_pkg::PC_ONE : crp_pkg::PC_DIGITS;
                crp_pkg::PC_ONE:          res = crp_pkg::PC_DIGITS;
                crp_pkg::PC_ONE_DOT:
                    res = (c == crp_pkg::CH_ZERO) ? crp_pkg::PC_ONE_DOT_ZERO
                                                  : crp_pkg::PC_VERSION;
                crp_pkg::PC_ONE_DOT_ZERO: res = crp_pkg::PC_VERSION;
                crp_pkg::PC_DIGITS:       res = crp_pkg::PC_DIGITS;
                crp_pkg::PC_DIGITS_DOT:   res = crp_pkg::PC_VERSION;
                crp_pkg::PC_VERSION:      res = crp_pkg::PC_VERSION;
                default:                  res = crp_pkg::PC_BAD;
            endcase
        end else if (c == crp_pkg::CH_DOT) begin
            case (pc)
                crp_pkg::PC_ONE:    res = crp_pkg::PC_ONE_DOT;
                crp_pkg::PC_DIGITS: res = crp_pkg::PC_DIGITS_DOT;
                default:            res = crp_pkg::PC_BAD;
            endcase
        end
        return res;
    endfunction

    // Run one byte through the verb and parameter matchers.
    function automatic crp_pkg::t_crp_line feed(
        input logic [7:0] c,
        input crp_pkg::t_crp_line s,
        input logic [crp_pkg::LC_W-1:0] pos
    );
        crp_pkg::t_crp_line res;
        logic [1:0] idx;
        res = s;
        idx = pos[1:0];
        if (s.in_parameter) begin
            res.param_class = next_pclass(c, s.param_class);
        end else if (c == crp_pkg::CH_SPACE) begin
            if (pos != crp_pkg::LC_W'(4)) begin
                res.verb_match = 2'b00;
            end
            res.in_parameter = 1'b1;
        end else if (pos >= crp_pkg::LC_W'(4)) begin
            res.verb_match = 2'b00;
        end else begin
            if (c != crp_pkg::NOOP_WORD[8*(3-idx) +: 8]) begin
                res.verb_match[0] = 1'b0;
            end
            if (c != crp_pkg::EHLO_WORD[8*(3-idx) +: 8]) begin
                res.verb_match[1] = 1'b0;
            end
        end
        return res;
    endfunction

    assign o_in_ready = i_can_push;
    assign acc        = i_in_valid && o_in_ready;
    assign count_inc  = {1'b0, r_count} + (crp_pkg::LC_W+1)'(1);
    assign matched    = r_count - crp_pkg::LC_W'(r_pend_cr);

    // Line datapath: matchers, byte count and the result event.
    always_comb begin
        n_line    = r_line;
        n_count   = r_count;
        n_pend_cr = r_pend_cr;
        has_res   = 1'b0;
        res_ev    = crp_pkg::EV_BANNER;
        fed       = r_line;
        fin       = r_line;
        if (acc) begin
            if (i_in_data.operation == crp_pkg::OP_OPEN) begin
                if (r_phase == crp_pkg::PH_WAIT) begin
                    n_line    = crp_pkg::LINE_CLEAR;
                    n_count   = '0;
                    n_pend_cr = 1'b0;
                    has_res   = 1'b1;
                    res_ev    = crp_pkg::EV_BANNER;
                end
            end else if (r_phase == crp_pkg::PH_CMD) begin
                if (i_in_data.data_byte == crp_pkg::CH_LF) begin
                    // Drop a trailing CR; the verb alone must be exactly four bytes.
                    if (!r_line.in_parameter && matched != crp_pkg::LC_W'(4)) begin
                        fin.verb_match = 2'b00;
                    end
                    has_res = 1'b1;
                    if (fin.verb_match[0]) begin
                        res_ev = crp_pkg::EV_OK;
                    end else if (fin.verb_match[1]) begin
                        if (fin.param_class == crp_pkg::PC_EMPTY ||
                            fin.param_class == crp_pkg::PC_ONE_DOT_ZERO) begin
                            res_ev = crp_pkg::EV_CAP;
                        end else if (fin.param_class == crp_pkg::PC_VERSION) begin
                            res_ev = crp_pkg::EV_VERSION;
                        end else begin
                            res_ev = crp_pkg::EV_SYNTAX;
                        end
                    end else begin
                        res_ev = crp_pkg::EV_UNKNOWN;
                    end
                    n_line    = crp_pkg::LINE_CLEAR;
                    n_count   = '0;
                    n_pend_cr = 1'b0;
                end else begin
                    // A held CR that is not followed by LF is an ordinary byte.
                    if (r_pend_cr) begin
                        fed = feed(crp_pkg::CH_CR, fed, r_count);
                    end
                    if (i_in_data.data_byte != crp_pkg::CH_CR) begin
                        fed = feed(i_in_data.data_byte, fed, r_count);
                    end
                    if (count_inc == (crp_pkg::LC_W+1)'(crp_pkg::MAX_LINE)) begin
                        n_line    = crp_pkg::LINE_CLEAR;
                        n_count   = '0;
                        n_pend_cr = 1'b0;
                        has_res   = 1'b1;
                        res_ev    = crp_pkg::EV_SYNTAX;
                    end else begin
                        n_line    = fed;
                        n_count   = count_inc[crp_pkg::LC_W-1:0];
                        n_pend_cr = (i_in_data.data_byte == crp_pkg::CH_CR);
                    end
                end
            end
        end
    end

    // Session phase: next state.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            crp_pkg::PH_WAIT: begin
                if (has_res) begin
                    n_phase = crp_pkg::PH_CMD;
                end
            end
            crp_pkg::PH_CMD: begin
                if (has_res && crp_pkg::ev_closes(res_ev)) begin
                    n_phase = crp_pkg::PH_CLOSED;
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    // Session phase: outputs.
    always_comb begin
        o_push       = 1'b0;
        o_push_event = res_ev;
        case (r_phase)
            crp_pkg::PH_WAIT, crp_pkg::PH_CMD: o_push = has_res;
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= crp_pkg::PH_WAIT;
            r_line    <= crp_pkg::LINE_CLEAR;
            r_count   <= '0;
            r_pend_cr <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_line    <= n_line;
            r_count   <= n_count;
            r_pend_cr <= n_pend_cr;
        end
    end

endmodule

### rtl/crp_queue.sv
module crp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  crp_pkg::t_crp_event    i_push_event,
    input  logic                   i_pop,
    output crp_pkg::t_crp_event    o_head_event,
    output crp_pkg::t_crp_q_status o_status
);

    crp_pkg::t_crp_event r_slot [crp_pkg::Q_DEPTH];
    logic [crp_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [crp_pkg::Q_AW:0]   r_fill, n_fill;
    logic                     do_push, do_pop;

    assign o_status.full  = (r_fill == (crp_pkg::Q_AW+1)'(crp_pkg::Q_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head_event   = r_slot[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + (crp_pkg::Q_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - (crp_pkg::Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + crp_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + crp_pkg::Q_AW'(1);
            end
            r_fill <= n_fill;
        end
    end

endmodule

### rtl/crp_back.sv
module crp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  crp_pkg::t_crp_event    i_head_event,
    input  crp_pkg::t_crp_q_status i_q_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output crp_pkg::t_crp_out      o_out_data
);

    logic              r_starttls;
    logic              r_valid, n_valid;
    crp_pkg::t_crp_out r_data, n_data;

    assign o_pop       = !i_q_status.empty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_pop) begin
            n_valid            = 1'b1;
            n_data.close_after = crp_pkg::ev_closes(i_head_event);
            case (i_head_event)
                crp_pkg::EV_BANNER:  n_data.reply_code = crp_pkg::RC_BANNER;
                crp_pkg::EV_OK:      n_data.reply_code = crp_pkg::RC_OK;
                crp_pkg::EV_CAP:
                    n_data.reply_code = r_starttls ? crp_pkg::RC_TLSCAP : crp_pkg::RC_NOCAP;
                crp_pkg::EV_UNKNOWN: n_data.reply_code = crp_pkg::RC_UNKNOWN;
                crp_pkg::EV_VERSION: n_data.reply_code = crp_pkg::RC_VERSION;
                default:             n_data.reply_code = crp_pkg::RC_SYNTAX;
            endcase
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_starttls <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_wr_en) begin
                r_starttls <= i_cfg_wr_data;
            end
        end
    end

endmodule

### rtl/command_line_reply_parser_unit.sv
// Line-oriented command receiver: an open transfer answers the banner, then
// received bytes are parsed one per cycle while input ready is high into
// LF-terminated command lines (NOOP, EHLO with an optional version) and each
// finished line gives one reply; error replies close the session. One item is
// taken every cycle while input ready is high. The front parser keeps only
// small match registers and pushes one event per reply into a four-entry
// queue; the back stage maps it to a reply code and holds it in the output
// register. Input ready drops only while that queue is full, that is once
// five replies wait (four queued and one held at the output) while the output
// side stalls. Replies from the configuration register use its value at the
// time the reply leaves the queue.
module command_line_reply_parser_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  crp_pkg::t_crp_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output crp_pkg::t_crp_out o_out_data
);

    logic                   push, pop;
    crp_pkg::t_crp_event    push_event, head_event;
    crp_pkg::t_crp_q_status q_status;

    crp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_can_push   (!q_status.full),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_push_event (push_event)
    );

    crp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_event (push_event),
        .i_pop        (pop),
        .o_head_event (head_event),
        .o_status     (q_status)
    );

    crp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_event  (head_event),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

### rtl/crp_checker.sv
`include "command_line_reply_parser_unit_defines.svh"

module crp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input crp_pkg::t_crp_out o_out_data
);

    // Hold a stalled reply.
    `CRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "reply changed while stalled")

    `CRP_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_out_valid, o_out_data.reply_code != 3'd7, "reply code out of range")

    // Error replies, and only they, close the session.
    `CRP_ASSERT_NOW(a_close_err, i_clk, i_rst_n, o_out_valid, o_out_data.close_after == (o_out_data.reply_code == crp_pkg::RC_SYNTAX || o_out_data.reply_code == crp_pkg::RC_UNKNOWN || o_out_data.reply_code == crp_pkg::RC_VERSION), "close flag does not match reply")

endmodule

bind command_line_reply_parser_unit crp_checker u_crp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
